>>> sv/swm_pkg.sv
// shared types and constants for the star wildcard matcher
`timescale 1ns / 1ps

package swm_pkg;

	localparam int PAT_LEN = 16;
	localparam int COL_W   = PAT_LEN + 1;
	localparam int LEN_W   = $clog2(PAT_LEN + 1);
	localparam int BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LENGTH = 2'd2;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_MID,
		KIND_LAST,
		KIND_EMPTY
	} item_kind_t;

	// one classified word waiting for the column update
	typedef struct packed {
		item_kind_t         kind;
		logic [PAT_LEN-1:0] hit;
	} q_entry_t;

	// pattern decoded from the configuration registers
	typedef struct packed {
		logic [PAT_LEN-1:0][BYTE_W-1:0] chars;
		logic [PAT_LEN-1:0]             used;
		logic [PAT_LEN-1:0]             star;
		logic [COL_W-1:0]               start;
		logic [COL_W-1:0]               end_sel;
	} pat_info_t;

endpackage

>>> sv/swm_front.sv
// front end: takes text words and turns each into a per-position hit mask
`timescale 1ns / 1ps

module swm_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [swm_pkg::BYTE_W-1:0]     s_tdata,
	input  logic                           s_tlast,
	input  logic                           s_tuser,
	input  swm_pkg::pat_info_t             pat,
	input  logic                           q_full,
	output logic                           q_push,
	output swm_pkg::q_entry_t              q_wdata
);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		if (s_tuser) begin
			q_wdata.kind = swm_pkg::KIND_EMPTY;
		end else if (s_tlast) begin
			q_wdata.kind = swm_pkg::KIND_LAST;
		end else begin
			q_wdata.kind = swm_pkg::KIND_MID;
		end
		// a star position matches any byte, others only their own byte
		for (int k = 0; k < swm_pkg::PAT_LEN; k++) begin
			q_wdata.hit[k] = pat.used[k] && (pat.star[k] || (pat.chars[k] == s_tdata));
		end
	end

endmodule

>>> sv/swm_queue.sv
// two-word queue between the front and back ends
`timescale 1ns / 1ps

module swm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swm_pkg::q_entry_t wdata,
	output logic              full,
	output logic              rvalid,
	input  logic              pop,
	output swm_pkg::q_entry_t rdata
);

	swm_pkg::q_entry_t                mem_q [swm_pkg::QUEUE_DEPTH];
	logic [swm_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [swm_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [swm_pkg::QCNT_W-1:0]       count_q;
	logic                             do_pop;

	assign full   = (count_q == swm_pkg::QCNT_W'(swm_pkg::QUEUE_DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];
	assign do_pop = pop && rvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> sv/swm_back.sv
// back end: match column update and result register
`timescale 1ns / 1ps

module swm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::pat_info_t            pat,
	input  logic                          cfg_reload,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  swm_pkg::q_entry_t             q_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [swm_pkg::BYTE_W-1:0]    m_tdata
);

	logic [swm_pkg::COL_W-1:0] col_q;
	logic [swm_pkg::COL_W-1:0] col_next;
	logic                      out_valid_q;
	logic                      matched_q;
	logic                      pop;
	logic                      gives_result;
	logic                      result_bit;

	assign gives_result = (q_data.kind != swm_pkg::KIND_MID);
	assign q_ready      = !gives_result || !out_valid_q || m_tready;
	assign pop          = q_valid && q_ready;

	// ripple of the recurrence down the pattern, like a carry chain
	always_comb begin
		col_next[0] = 1'b0;
		for (int k = 0; k < swm_pkg::PAT_LEN; k++) begin
			col_next[k+1] = (col_q[k] && q_data.hit[k])
				|| (col_q[k+1] && pat.star[k])
				|| (col_next[k] && pat.star[k]);
		end
	end

	always_comb begin
		case (q_data.kind)
			swm_pkg::KIND_EMPTY: result_bit = |(pat.start & pat.end_sel);
			swm_pkg::KIND_LAST:  result_bit = |(col_next & pat.end_sel);
			default:             result_bit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= swm_pkg::COL_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_reload) begin
				col_q <= pat.start;
			end else if (pop) begin
				col_q <= gives_result ? pat.start : col_next;
			end
			if (pop && gives_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && gives_result) begin
			matched_q <= result_bit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(swm_pkg::BYTE_W-1){1'b0}}, matched_q};

endmodule

>>> sv/star_wildcard_matcher.sv
// top level of the star wildcard matcher
`timescale 1ns / 1ps

// Matches text strings, streamed one byte per word, against a pattern of up to
// sixteen bytes in which '*' matches any run of bytes (the empty run too) and
// every other byte matches only itself. A word with tuser set stands for an
// empty string; a word with tlast set ends a string. Each of those gives one
// result word whose bit 0 says whether the whole string matched the whole
// pattern; other words give none. The block takes one word per clock cycle
// while the queue is not full. The single column update in the back end is
// a one-bit ripple across the sixteen pattern positions. The front end
// classifies each word into a hit mask, a two-word queue decouples it from
// the back end, and the result sits in an output register so words that
// give no result keep flowing while it waits. The pattern is written through
// the configuration channel (index 0: bytes 0 to 7, index 1: bytes 8 to 15,
// index 2: length, saturated at sixteen); a write to one of these restarts
// a string in progress and must be made while idle.

module star_wildcard_matcher (
	input  logic                              clk,
	input  logic                              arst_n,
	// text words
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [swm_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] text_byte
	input  logic                              s_tlast,   // is_last
	input  logic                              s_tuser,   // [0] is_empty
	// result words
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swm_pkg::BYTE_W-1:0]        m_tdata,   // [0] matched, [7:1] zero
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                       cfg_data
);

	logic [63:0]               chars_low_q;
	logic [63:0]               chars_high_q;
	logic [swm_pkg::LEN_W-1:0] pat_length_q;
	logic                      cfg_reload_q;
	logic [swm_pkg::LEN_W-1:0] len_used;
	logic                      cfg_hit;
	swm_pkg::pat_info_t        pat;

	logic                      q_push;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_ready;
	swm_pkg::q_entry_t         q_wdata;
	swm_pkg::q_entry_t         q_data;

	// configuration is always taken
	assign cfg_ready = 1'b1;
	assign cfg_hit   = (cfg_index == swm_pkg::REG_CHARS_LOW)
		|| (cfg_index == swm_pkg::REG_CHARS_HIGH)
		|| (cfg_index == swm_pkg::REG_PAT_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q  <= '0;
			chars_high_q <= '0;
			pat_length_q <= '0;
			cfg_reload_q <= 1'b0;
		end else begin
			// the column reload follows in the next cycle, once the pattern has settled
			cfg_reload_q <= cfg_valid && cfg_hit;
			if (cfg_valid) begin
				case (cfg_index)
					swm_pkg::REG_CHARS_LOW:  chars_low_q  <= cfg_data;
					swm_pkg::REG_CHARS_HIGH: chars_high_q <= cfg_data;
					swm_pkg::REG_PAT_LENGTH: pat_length_q <= cfg_data[swm_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// pattern decode: used positions, stars, start column and end position
	assign len_used = (pat_length_q > swm_pkg::LEN_W'(swm_pkg::PAT_LEN))
		? swm_pkg::LEN_W'(swm_pkg::PAT_LEN) : pat_length_q;

	always_comb begin
		pat.chars    = {chars_high_q, chars_low_q};
		pat.start[0] = 1'b1;
		for (int k = 0; k < swm_pkg::PAT_LEN; k++) begin
			pat.used[k]    = (swm_pkg::LEN_W'(k) < len_used);
			pat.star[k]    = pat.used[k] && (pat.chars[k] == swm_pkg::STAR_CHAR);
			// leading stars let the start column reach further down
			pat.start[k+1] = pat.start[k] && pat.star[k];
		end
		for (int i = 0; i < swm_pkg::COL_W; i++) begin
			pat.end_sel[i] = (swm_pkg::LEN_W'(i) == len_used);
		end
	end

	swm_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.pat      (pat),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	swm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rvalid (q_valid),
		.pop    (q_ready),
		.rdata  (q_data)
	);

	swm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pat        (pat),
		.cfg_reload (cfg_reload_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_data     (q_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// exactly one pattern position closes the match
	a_end_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(pat.end_sel))
		else $error("end position select not one-hot");

	// a taken word lands in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> q_valid)
		else $error("accepted word missing from queue");

	// a final or empty word popped by the back end yields a result word
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && (q_data.kind != swm_pkg::KIND_MID) |=> m_tvalid)
		else $error("result word missing after final word");

endmodule

>>> tb/star_wildcard_matcher_tb.sv
// self-checking testbench for the star wildcard matcher
`timescale 1ns / 1ps

module star_wildcard_matcher_tb;
	import swm_pkg::*;

	// index 3 is not a register, a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [BYTE_W-1:0] CH_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_B   = 8'h62;
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_FF  = 8'hFF;

	localparam int unsigned WORD_TARGET  = 1900;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	// margin for the block to drain after the last result
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned REPORT_MAX   = 10;

	typedef logic [BYTE_W-1:0] text_q_t[$];

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	// keeps its own copy of the pattern and the match column, predicts the
	// matched flag of every final or empty word and checks result words in order
	class match_scoreboard;
		logic [63:0]       chars_lo;
		logic [63:0]       chars_hi;
		logic [4:0]        len_reg;
		logic [COL_W-1:0]  column;
		bit                matched_q[$];
		int unsigned       errors;

		function new();
			chars_lo = '0;
			chars_hi = '0;
			len_reg  = '0;
			errors   = 0;
			column   = start_col();
		endfunction

		// length register saturates at the pattern size
		function int unsigned used_len();
			int unsigned n;
			n = 32'(len_reg);
			if (n > PAT_LEN)
				n = PAT_LEN;
			return n;
		endfunction

		function logic [BYTE_W-1:0] pat_byte(int unsigned pos);
			if (pos < 8)
				return chars_lo[pos*8 +: 8];
			return chars_hi[(pos-8)*8 +: 8];
		endfunction

		// position zero plus every position reached through leading stars only
		function logic [COL_W-1:0] start_col();
			logic [COL_W-1:0] col;
			col = COL_W'(1);
			for (int unsigned i = 0; i < used_len(); i++) begin
				if (pat_byte(i) != STAR_CHAR)
					break;
				col[i+1] = 1'b1;
			end
			return col;
		endfunction

		// one text byte: diagonal step on a literal hit or a star, a star may
		// also keep the previous column bit or ripple down from the bit above
		function logic [COL_W-1:0] step_col(logic [COL_W-1:0] prev, logic [BYTE_W-1:0] c);
			logic [COL_W-1:0] col;
			logic             star;
			col = '0;
			for (int unsigned i = 1; i <= used_len(); i++) begin
				star   = (pat_byte(i-1) == STAR_CHAR);
				col[i] = (prev[i-1] && (star || pat_byte(i-1) == c))
					|| (star && (prev[i] || col[i-1]));
			end
			return col;
		endfunction

		function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				REG_CHARS_LOW:  chars_lo = data;
				REG_CHARS_HIGH: chars_hi = data;
				REG_PAT_LENGTH: len_reg  = data[4:0];
				default:        return;
			endcase
			// any real write restarts a string in progress
			column = start_col();
		endfunction

		function void note_text_word(logic [BYTE_W-1:0] c, logic last, logic empty);
			if (empty) begin
				column = start_col();
				matched_q.push_back(column[used_len()]);
			end else begin
				column = step_col(column, c);
				if (last) begin
					matched_q.push_back(column[used_len()]);
					column = start_col();
				end
			end
		endfunction

		function void check_result(logic [BYTE_W-1:0] got);
			bit want;
			if (matched_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result word %02h with no result expected", got);
				return;
			end
			want = matched_q.pop_front();
			if (got[0] !== want || got[BYTE_W-1:1] !== '0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result mismatch: expected matched=%0b pad=00, got matched=%0b pad=%02h",
						want, got[0], got[BYTE_W-1:1]);
			end
		endfunction

		function int unsigned pending();
			return matched_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] text_byte
	logic                 s_tlast   = 1'b0; // is_last
	logic                 s_tuser   = 1'b0; // [0] is_empty
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;          // [0] matched, [7:1] zero
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	match_scoreboard sb = new();

	text_q_t     line_buf;
	int unsigned words_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned burst_max   = 0;   // zero means the sender never pauses
	int unsigned hold_asks   = 0;   // bumped by the stimulus to ask for a long stall
	int unsigned hold_done   = 0;
	int unsigned hold_left   = 0;
	int unsigned mode_left   = 0;
	int unsigned cycle_count = 0;
	rx_mode_t    rx_mode     = RX_OPEN;

	star_wildcard_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs or drops a result
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("star_wildcard_matcher_tb failed");
			$finish;
		end
	end

	// receiver: a long hold when asked, otherwise a randomly chosen stall
	// pattern, including stretches of no stalling at all
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_done) begin
			hold_done++;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ~m_tready;
			endcase
		end
	end

	// result monitor, sampled at the edge that moves the word
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_result(m_tdata);
	end

	// offer one text word and wait for it to be taken; a burst that runs out
	// first drops valid for a short random gap
	task automatic offer(input logic [BYTE_W-1:0] c, input logic last, input logic empty);
		if (burst_max != 0 && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = $urandom_range(1, burst_max);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		s_tuser  <= empty;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_text_word(c, last, empty);
		words_sent++;
		if (burst_left != 0)
			burst_left--;
	endtask

	// whole string from line_buf; an empty buffer goes out as an empty-string
	// word with junk in the byte and the last flag
	task automatic send_text();
		if (line_buf.size() == 0) begin
			offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			foreach (line_buf[i])
				offer(line_buf[i], i == line_buf.size() - 1, 1'b0);
		end
	endtask

	// string without its last flag, left open in the block
	task automatic send_partial();
		foreach (line_buf[i])
			offer(line_buf[i], 1'b0, 1'b0);
	endtask

	// input quiet, every result back, then the block's own latency
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.note_reg_write(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// small alphabet so that literals hit often, with stars, zero bytes and
	// the odd fully random byte
	function automatic logic [BYTE_W-1:0] pick_char();
		case ($urandom_range(0, 7))
			0, 1:    return CH_A;
			2, 3:    return CH_B;
			4:       return CH_NUL;
			5:       return CH_FF;
			6:       return STAR_CHAR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pattern_char();
		if ($urandom_range(0, 99) < 35)
			return STAR_CHAR;
		return pick_char();
	endfunction

	function automatic void fill_alpha(int unsigned n);
		line_buf = {};
		repeat (n) line_buf.push_back(pick_char());
	endfunction

	// text that matches the current pattern: literals copied, each star
	// expanded into zero to three bytes
	function automatic void fill_matching();
		line_buf = {};
		for (int unsigned i = 0; i < sb.used_len(); i++) begin
			if (sb.pat_byte(i) == STAR_CHAR)
				repeat ($urandom_range(0, 3)) line_buf.push_back(pick_char());
			else
				line_buf.push_back(sb.pat_byte(i));
		end
	endfunction

	// spoil a matching text by one replaced, dropped or extra byte
	function automatic void mutate_text();
		int unsigned n;
		n = line_buf.size();
		case ($urandom_range(0, 2))
			0: if (n != 0) line_buf[$urandom_range(0, n - 1)] = pick_char();
			1: if (n != 0) line_buf.delete($urandom_range(0, n - 1));
			default: line_buf.insert($urandom_range(0, n), pick_char());
		endcase
	endfunction

	// new pattern through all three registers, length word carrying random
	// upper bits; length is sometimes zero, full or beyond the limit
	task automatic load_random_pattern(input bit full_len);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;
		int unsigned n;
		case ($urandom_range(0, 9))
			0:       n = 0;
			1:       n = PAT_LEN;
			2:       n = $urandom_range(PAT_LEN + 1, 31);
			default: n = $urandom_range(1, PAT_LEN);
		endcase
		if (full_len)
			n = PAT_LEN;
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = pattern_char();
			hi[i*8 +: 8] = pattern_char();
		end
		if ($urandom_range(0, 5) == 0)
			lo = {$urandom, $urandom};
		if ($urandom_range(0, 5) == 0)
			hi = {$urandom, $urandom};
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = LEN_W'(n);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_PAT_LENGTH, len_word);
			write_reg(REG_CHARS_HIGH, hi);
			write_reg(REG_CHARS_LOW, lo);
		end else begin
			write_reg(REG_CHARS_LOW, lo);
			write_reg(REG_CHARS_HIGH, hi);
			write_reg(REG_PAT_LENGTH, len_word);
		end
	endtask

	// mostly well-formed texts with random content, the rest noise
	task automatic send_random_string();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			fill_matching();
			if ($urandom_range(0, 9) < 3)
				mutate_text();
			send_text();
		end else if (pick < 72) begin
			fill_alpha($urandom_range(1, 6));
			send_text();
		end else if (pick < 82) begin
			line_buf = {};
			repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
			send_text();
		end else if (pick < 90) begin
			line_buf = {};
			send_text();
		end else begin
			// empty word in the middle of a string
			fill_alpha($urandom_range(1, 3));
			send_partial();
			offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	task automatic run_phase(input int unsigned n_words, input bit with_hold);
		int unsigned goal;
		goal       = words_sent + n_words;
		burst_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 16);
		burst_left = 0;
		if (with_hold) begin
			// receiver stops for a long stretch while short strings keep
			// coming, so queue and output register fill and input stalls
			hold_asks <= hold_asks + 1;
			burst_max = 0;
			repeat (40) begin
				if ($urandom_range(0, 1) == 0)
					offer(pick_char(), 1'b1, 1'b0);
				else
					offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end
		end
		while (words_sent < goal)
			send_random_string();
	endtask

	initial begin
		int unsigned phase_no;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern is empty: only the empty string matches
		line_buf = {};                  send_text();
		line_buf = '{CH_NUL};           send_text();
		line_buf = '{CH_A, CH_B};       send_text();
		settle();

		// star, 'a', zero byte, star; bytes past the length all ones
		write_reg(REG_CHARS_LOW, 64'hFFFF_FFFF_2A00_612A);
		write_reg(REG_CHARS_HIGH, '1);
		write_reg(REG_PAT_LENGTH, 64'hFFFF_FFFF_FFFF_FFE4);
		line_buf = '{CH_A, CH_NUL};                          send_text();
		line_buf = '{CH_FF, CH_A, CH_NUL, STAR_CHAR, CH_NUL}; send_text();
		line_buf = '{CH_A};                                  send_text();
		line_buf = '{STAR_CHAR, CH_A, CH_NUL};               send_text();
		// empty word mid-string drops the partial string
		line_buf = '{CH_A};
		send_partial();
		offer(CH_FF, 1'b1, 1'b1);
		line_buf = '{CH_A, CH_NUL};                          send_text();
		settle();

		// all sixteen bytes stars, length register far beyond the limit
		write_reg(REG_CHARS_LOW, {8{STAR_CHAR}});
		write_reg(REG_CHARS_HIGH, {8{STAR_CHAR}});
		write_reg(REG_PAT_LENGTH, 64'h1F);
		line_buf = {};                            send_text();
		line_buf = '{CH_FF};                      send_text();
		line_buf = '{CH_NUL, CH_FF, STAR_CHAR};   send_text();
		settle();

		// pattern "ab": the unused index leaves an open string alone
		write_reg(REG_CHARS_LOW, 64'({CH_B, CH_A}));
		write_reg(REG_PAT_LENGTH, 64'(2));
		line_buf = '{CH_A};
		send_partial();
		settle();
		write_reg(REG_UNUSED, '1);
		line_buf = '{CH_B};
		send_text();
		// while a real write throws it away
		line_buf = '{CH_A};
		send_partial();
		settle();
		write_reg(REG_PAT_LENGTH, 64'(2));
		line_buf = '{CH_B};
		send_text();
		settle();

		// random phases, each on a fresh pattern
		phase_no = 0;
		while (words_sent < WORD_TARGET) begin
			load_random_pattern(phase_no == 0);
			run_phase($urandom_range(100, 220), phase_no == 2);
			// sometimes leave a string open for the next pattern load to discard
			if ($urandom_range(0, 2) == 0) begin
				fill_alpha($urandom_range(1, 3));
				send_partial();
			end
			settle();
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});
			phase_no++;
		end
		settle();

		if (sb.errors == 0)
			$display("star_wildcard_matcher_tb passed");
		else
			$display("star_wildcard_matcher_tb failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/swm_pkg.sv
sv/swm_front.sv
sv/swm_queue.sv
sv/swm_back.sv
sv/star_wildcard_matcher.sv
tb/star_wildcard_matcher_tb.sv
